FILE: rtl/core/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the current loop pressure averager: field
// widths, configuration register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package cpa_pkg;

	// Fixed field widths
	localparam int SAMPLE_W   = 12;
	localparam int PRESS_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESSURE_LOW    = 3'd0,
		REG_PRESSURE_HIGH   = 3'd1,
		REG_ADC_LOW         = 3'd2,
		REG_ADC_HIGH        = 3'd3,
		REG_VALID_THRESHOLD = 3'd4
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_PGO,
		ST_PWAIT,
		ST_WRITE,
		ST_SUM,
		ST_DRAIN,
		ST_MEAN,
		ST_MGO,
		ST_MWAIT,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/core/cpa_if.sv
// ----------------------------------------------------------------------------
// cpa_sample_if / cpa_result_if
// Valid/ready channels for the ADC sample and for the averaged result.
// ----------------------------------------------------------------------------
interface cpa_sample_if;
	logic                         valid;
	logic                         ready;
	logic [cpa_pkg::SAMPLE_W-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

interface cpa_result_if;
	logic                        valid;
	logic                        ready;
	logic [cpa_pkg::PRESS_W-1:0] pressure;
	logic [cpa_pkg::PRESS_W-1:0] mean_pressure;
	logic                        mean_valid;

	modport source (output valid, output pressure, output mean_pressure,
		output mean_valid, input ready);
	modport sink   (input valid, input pressure, input mean_pressure,
		input mean_valid, output ready);
endinterface

FILE: rtl/core/cpa_div.sv
// ----------------------------------------------------------------------------
// cpa_div
// Shared unsigned restoring divider, one quotient bit per cycle. A start
// pulse loads the operands; done pulses once when the quotient is final.
// ----------------------------------------------------------------------------
module cpa_div #(
	parameter int N_W = 28,
	parameter int D_W = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CW = $clog2(N_W + 1);

	logic [D_W:0]   rem_q;
	logic [N_W-1:0] quo_q;
	logic [D_W-1:0] dsr_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [D_W:0]   rem_sh;
	logic           ge;
	logic [D_W:0]   rem_nx;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		rem_sh = {rem_q[D_W-1:0], quo_q[N_W-1]};
		ge     = (rem_sh >= {1'b0, dsr_q});
		rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(N_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/cpa_ring.sv
// ----------------------------------------------------------------------------
// cpa_ring
// Ring of recent pressures: one write port, one registered read port. Each
// entry has a valid bit cleared at reset; an entry never written reads zero.
// ----------------------------------------------------------------------------
module cpa_ring #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [IDX_W-1:0]            waddr,
	input  logic [cpa_pkg::PRESS_W-1:0] wdata,
	input  logic [IDX_W-1:0]            raddr,
	output logic [cpa_pkg::PRESS_W-1:0] rdata
);

	logic [cpa_pkg::PRESS_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]            vld_q;
	logic [cpa_pkg::PRESS_W-1:0] rd_s1;
	logic                        rd_vld_s1;

	// Write entries
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Track written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rd_s1     <= mem[raddr];
		rd_vld_s1 <= vld_q[raddr];
	end

	assign rdata = rd_vld_s1 ? rd_s1 : '0;

endmodule

FILE: rtl/core/current_loop_pressure_averager.sv
// ----------------------------------------------------------------------------
// current_loop_pressure_averager
// Scales a 4-20 mA loop ADC sample to pressure and averages recent pressures
// above a threshold.
// ----------------------------------------------------------------------------
// One sample is taken at a time: while a sample is in work, sample.ready is
// low. The time a sample takes is set by two passes through the shared
// bit-serial divider (one for the linear scaling, one for the mean) and one
// read sweep over the sample ring; the mean pass is skipped when no ring
// entry lies above the threshold. The result sits in an output register, so
// the next sample can be taken while the result waits. Configuration writes
// are registered and must be made while the block is idle.
// ----------------------------------------------------------------------------
module current_loop_pressure_averager #(
	parameter int RING_DEPTH = 16,
	parameter int ADC_BITS   = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cpa_sample_if.sink                    sample,
	cpa_result_if.source                  result,
	input  logic                          cfg_we,
	input  logic [cpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int PW      = cpa_pkg::PRESS_W;
	localparam int ADC_W   = (ADC_BITS < cpa_pkg::SAMPLE_W) ? ADC_BITS : cpa_pkg::SAMPLE_W;
	localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W   = $clog2(RING_DEPTH + 1);
	localparam int SUM_W   = PW + CNT_W;
	localparam int PROD_W  = PW + ADC_W;
	localparam int DIV_N_W = (PROD_W > SUM_W) ? PROD_W : SUM_W;
	localparam int DIV_D_W = (ADC_W > CNT_W) ? ADC_W : CNT_W;

	// Configuration registers
	logic [PW-1:0]    p_low_q;
	logic [PW-1:0]    p_high_q;
	logic [ADC_W-1:0] a_low_q;
	logic [ADC_W-1:0] a_high_q;
	logic [PW-1:0]    thr_q;

	// Sequencer and datapath
	cpa_pkg::state_t  state_q;
	cpa_pkg::state_t  state_nx;
	logic [ADC_W-1:0] s_q;
	logic [PROD_W-1:0] prod_q;
	logic [ADC_W-1:0] den_q;
	logic             neg_q;
	logic [PW-1:0]    press_q;
	logic [IDX_W-1:0] wp_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_vld_s1;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0]    held_mean_q;
	logic             mvalid_q;

	// Output register
	logic             res_valid_q;
	logic [PW-1:0]    res_press_q;
	logic [PW-1:0]    res_mean_q;
	logic             res_mvalid_q;

	// Control decodes
	logic             in_ready;
	logic             div_start;
	logic             ring_we;
	logic             sweep;
	logic             out_load;

	// Combinational datapath
	logic             span_empty;
	logic [ADC_W-1:0] s_clamp;
	logic [ADC_W-1:0] s_off;
	logic             p_neg;
	logic [PW-1:0]    p_mag;
	logic [PROD_W-1:0] prod_c;
	logic [PW-1:0]    quo16;
	logic [PW-1:0]    press_c;
	logic [PW-1:0]    ring_rdata;

	logic [DIV_N_W-1:0] div_dividend;
	logic [DIV_D_W-1:0] div_divisor;
	logic               div_done;
	logic [DIV_N_W-1:0] div_quo;

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_low_q  <= '0;
			p_high_q <= PW'(1);
			a_low_q  <= '0;
			a_high_q <= '1;
			thr_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpa_pkg::REG_PRESSURE_LOW:    p_low_q  <= cfg_wdata[PW-1:0];
				cpa_pkg::REG_PRESSURE_HIGH:   p_high_q <= cfg_wdata[PW-1:0];
				cpa_pkg::REG_ADC_LOW:         a_low_q  <= cfg_wdata[ADC_W-1:0];
				cpa_pkg::REG_ADC_HIGH:        a_high_q <= cfg_wdata[ADC_W-1:0];
				cpa_pkg::REG_VALID_THRESHOLD: thr_q    <= cfg_wdata[PW-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the sample and form the scaling product
	always_comb begin
		span_empty = (a_high_q <= a_low_q);
		if (s_q < a_low_q) begin
			s_clamp = a_low_q;
		end else if (s_q > a_high_q) begin
			s_clamp = a_high_q;
		end else begin
			s_clamp = s_q;
		end
		s_off  = s_clamp - a_low_q;
		p_neg  = (p_high_q < p_low_q);
		p_mag  = p_neg ? (p_low_q - p_high_q) : (p_high_q - p_low_q);
		prod_c = p_mag * s_off;
	end

	// Apply the truncated offset with the sign of the slope
	always_comb begin
		quo16   = div_quo[PW-1:0];
		press_c = neg_q ? (p_low_q - quo16) : (p_low_q + quo16);
	end

	// Feed the shared divider: scaling pass or mean pass
	always_comb begin
		if (state_q == cpa_pkg::ST_MGO) begin
			div_dividend = DIV_N_W'(sum_q);
			div_divisor  = DIV_D_W'(cnt_q);
		end else begin
			div_dividend = DIV_N_W'(prod_q);
			div_divisor  = DIV_D_W'(den_q);
		end
	end

	cpa_div #(
		.N_W (DIV_N_W),
		.D_W (DIV_D_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	cpa_ring #(
		.DEPTH (RING_DEPTH),
		.IDX_W (IDX_W)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ring_we),
		.waddr  (wp_q),
		.wdata  (press_c),
		.raddr  (rd_idx_q),
		.rdata  (ring_rdata)
	);

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			cpa_pkg::ST_IDLE:  if (sample.valid) state_nx = cpa_pkg::ST_MUL;
			cpa_pkg::ST_MUL:   state_nx = cpa_pkg::ST_PGO;
			cpa_pkg::ST_PGO:   state_nx = cpa_pkg::ST_PWAIT;
			cpa_pkg::ST_PWAIT: if (div_done) state_nx = cpa_pkg::ST_WRITE;
			cpa_pkg::ST_WRITE: state_nx = cpa_pkg::ST_SUM;
			cpa_pkg::ST_SUM: begin
				if (rd_idx_q == IDX_W'(RING_DEPTH - 1)) state_nx = cpa_pkg::ST_DRAIN;
			end
			cpa_pkg::ST_DRAIN: state_nx = cpa_pkg::ST_MEAN;
			cpa_pkg::ST_MEAN: begin
				state_nx = (cnt_q != '0) ? cpa_pkg::ST_MGO : cpa_pkg::ST_OUT;
			end
			cpa_pkg::ST_MGO:   state_nx = cpa_pkg::ST_MWAIT;
			cpa_pkg::ST_MWAIT: if (div_done) state_nx = cpa_pkg::ST_OUT;
			cpa_pkg::ST_OUT:   if (out_load) state_nx = cpa_pkg::ST_IDLE;
			default:           state_nx = cpa_pkg::ST_IDLE;
		endcase
	end

	// State decodes
	always_comb begin
		in_ready  = (state_q == cpa_pkg::ST_IDLE);
		div_start = (state_q == cpa_pkg::ST_PGO) || (state_q == cpa_pkg::ST_MGO);
		ring_we   = (state_q == cpa_pkg::ST_WRITE);
		sweep     = (state_q == cpa_pkg::ST_SUM);
		out_load  = (state_q == cpa_pkg::ST_OUT) && (!res_valid_q || result.ready);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpa_pkg::ST_IDLE;
			wp_q        <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			held_mean_q <= '0;
			mvalid_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			rd_vld_s1 <= sweep;

			// Advance the ring write pointer and restart the sweep
			if (ring_we) begin
				wp_q     <= (wp_q == IDX_W'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				rd_idx_q <= '0;
				sum_q    <= '0;
				cnt_q    <= '0;
			end
			if (sweep && rd_idx_q != IDX_W'(RING_DEPTH - 1)) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end

			// Accumulate qualifying entries
			if (rd_vld_s1 && ring_rdata > thr_q) begin
				sum_q <= sum_q + SUM_W'(ring_rdata);
				cnt_q <= cnt_q + 1'b1;
			end

			if (state_q == cpa_pkg::ST_MEAN) begin
				mvalid_q <= (cnt_q != '0);
			end
			if (state_q == cpa_pkg::ST_MWAIT && div_done) begin
				held_mean_q <= div_quo[PW-1:0];
			end

			// Hold the result until the transaction completes
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (sample.valid && in_ready) begin
			s_q <= sample.adc_sample[ADC_W-1:0];
		end
		if (state_q == cpa_pkg::ST_MUL) begin
			prod_q <= span_empty ? '0 : prod_c;
			den_q  <= span_empty ? ADC_W'(1) : (a_high_q - a_low_q);
			neg_q  <= p_neg;
		end
		if (ring_we) begin
			press_q <= press_c;
		end
		if (out_load) begin
			res_press_q  <= press_q;
			res_mean_q   <= held_mean_q;
			res_mvalid_q <= mvalid_q;
		end
	end

	assign sample.ready         = in_ready;
	assign result.valid         = res_valid_q;
	assign result.pressure      = res_press_q;
	assign result.mean_pressure = res_mean_q;
	assign result.mean_valid    = res_mvalid_q;

	// Divider finishes only while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == cpa_pkg::ST_PWAIT || state_q == cpa_pkg::ST_MWAIT))
		else $error("divider done outside a wait state");

	// Qualifying count never exceeds the ring depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(RING_DEPTH))
		else $error("qualifying count beyond ring depth");

	// An accepted transaction starts the scaling step
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> (state_q == cpa_pkg::ST_MUL))
		else $error("accepted sample did not start scaling");

endmodule

FILE: sim/tb_current_loop_pressure_averager.sv
// ----------------------------------------------------------------------------
// tb_current_loop_pressure_averager
// Drives ADC samples into the pressure averager under several register
// settings and idling patterns. A local predictor tracks the scaling, the
// sample ring and the held mean. Each result transaction is compared field by
// field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_current_loop_pressure_averager;

	localparam int PRESS_W         = cpa_pkg::PRESS_W;
	localparam int SAMPLE_W        = cpa_pkg::SAMPLE_W;
	localparam int CFG_IDX_W       = cpa_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W      = cpa_pkg::CFG_DATA_W;
	localparam int RING_DEPTH      = 16;
	localparam int HANG_LIMIT      = 4000;
	localparam int SAMPLES_PER_SET = 100;
	localparam int SETS_PER_PHASE  = 4;
	localparam int REPORT_CAP      = 50;

	typedef struct packed {
		logic [PRESS_W-1:0] pressure;
		logic [PRESS_W-1:0] mean_pressure;
		logic               mean_valid;
	} pressure_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cpa_sample_if sample_ch ();
	cpa_result_if result_ch ();

	current_loop_pressure_averager #(
		.RING_DEPTH(RING_DEPTH),
		.ADC_BITS  (SAMPLE_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor copy of the registers and the averaging state
	logic [PRESS_W-1:0]  cfg_pressure_low;
	logic [PRESS_W-1:0]  cfg_pressure_high;
	logic [SAMPLE_W-1:0] cfg_adc_low;
	logic [SAMPLE_W-1:0] cfg_adc_high;
	logic [PRESS_W-1:0]  cfg_threshold;
	logic [PRESS_W-1:0]  pressure_ring [RING_DEPTH];
	int unsigned         ring_slot;
	logic [PRESS_W-1:0]  held_mean;

	pressure_result_t pending_results[$];
	int               mismatch_count = 0;
	int               quiet_cycles = 0;
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;

	always #5 clk = ~clk;

	// Clamp to the ADC span and map linearly onto the pressure span
	function automatic logic [PRESS_W-1:0] scale_to_pressure(logic [SAMPLE_W-1:0] raw);
		logic [SAMPLE_W-1:0] clamped;
		longint              adc_span;
		longint              press_span;
		longint              offset;
		if (cfg_adc_high <= cfg_adc_low)
			return cfg_pressure_low;
		clamped = raw;
		if (clamped < cfg_adc_low)
			clamped = cfg_adc_low;
		if (clamped > cfg_adc_high)
			clamped = cfg_adc_high;
		adc_span = longint'(cfg_adc_high) - longint'(cfg_adc_low);
		press_span = longint'(cfg_pressure_high) - longint'(cfg_pressure_low);
		offset = press_span * (longint'(clamped) - longint'(cfg_adc_low)) / adc_span;
		return PRESS_W'(longint'(cfg_pressure_low) + offset);
	endfunction

	// Store the new pressure and average the ring entries above threshold
	function automatic pressure_result_t average_with_sample(logic [SAMPLE_W-1:0] raw);
		pressure_result_t outcome;
		int unsigned      total;
		int unsigned      hits;
		outcome.pressure = scale_to_pressure(raw);
		pressure_ring[ring_slot] = outcome.pressure;
		ring_slot = (ring_slot + 1) % RING_DEPTH;
		total = 0;
		hits = 0;
		for (int i = 0; i < RING_DEPTH; i++) begin
			if (pressure_ring[i] > cfg_threshold) begin
				total += pressure_ring[i];
				hits++;
			end
		end
		if (hits != 0)
			held_mean = PRESS_W'(total / hits);
		outcome.mean_pressure = held_mean;
		outcome.mean_valid = (hits != 0);
		return outcome;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP)
			$display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Receiver: stall at the current rate
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Observe both channels mid-cycle; a transaction completes at the next edge
	always @(negedge clk) begin : channel_monitor
		pressure_result_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with none pending, pressure",
						result_ch.pressure, 0);
				end else begin
					want = pending_results.pop_front();
					if (result_ch.pressure !== want.pressure)
						report_mismatch("pressure", result_ch.pressure, want.pressure);
					if (result_ch.mean_pressure !== want.mean_pressure)
						report_mismatch("mean_pressure", result_ch.mean_pressure,
							want.mean_pressure);
					if (result_ch.mean_valid !== want.mean_valid)
						report_mismatch("mean_valid", result_ch.mean_valid,
							want.mean_valid);
				end
			end
			if (sample_ch.valid && sample_ch.ready)
				pending_results.push_back(average_with_sample(sample_ch.adc_sample));
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("current_loop_pressure_averager: mismatch");
				$finish;
			end
		end
	end

	// Write one register and mirror it in the predictor
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (cpa_pkg::cfg_reg_t'(idx))
			cpa_pkg::REG_PRESSURE_LOW:    cfg_pressure_low = value;
			cpa_pkg::REG_PRESSURE_HIGH:   cfg_pressure_high = value;
			cpa_pkg::REG_ADC_LOW:         cfg_adc_low = value[SAMPLE_W-1:0];
			cpa_pkg::REG_ADC_HIGH:        cfg_adc_high = value[SAMPLE_W-1:0];
			cpa_pkg::REG_VALID_THRESHOLD: cfg_threshold = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_setting(input logic [PRESS_W-1:0] p_low,
		input logic [PRESS_W-1:0] p_high, input logic [SAMPLE_W-1:0] a_low,
		input logic [SAMPLE_W-1:0] a_high, input logic [PRESS_W-1:0] thr);
		write_register(cpa_pkg::REG_PRESSURE_LOW, p_low);
		write_register(cpa_pkg::REG_PRESSURE_HIGH, p_high);
		// Junk in the unused upper bits of the ADC registers
		write_register(cpa_pkg::REG_ADC_LOW, {4'($urandom_range(0, 15)), a_low});
		write_register(cpa_pkg::REG_ADC_HIGH, {4'($urandom_range(0, 15)), a_high});
		write_register(cpa_pkg::REG_VALID_THRESHOLD, thr);
	endtask

	// Send one sample, idling first at the current rate once the block is ready
	task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			do @(negedge clk); while (!sample_ch.ready);
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.adc_sample <= raw;
		do @(negedge clk); while (!sample_ch.ready);
		@(posedge clk);
	endtask

	// Hold off the sender until every pending result has been taken
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_reset_values();
		send_sample('0);
		send_sample('1);
		send_sample(12'h800);
	endtask

	task automatic test_scaling();
		drain_results();
		write_setting(16'h0000, 16'hFFFF, 12'd0, 12'd4095, 16'h0000);
		send_sample(12'hFFF);
		send_sample(12'h001);
		send_sample(12'hAAA);
		send_sample(12'h555);
		// Falling scale
		drain_results();
		write_setting(16'hFFFF, 16'h0000, 12'd0, 12'd4095, 16'h0000);
		send_sample(12'h000);
		send_sample(12'hFFE);
		// Clamp samples outside a narrowed span
		drain_results();
		write_setting(16'd100, 16'd50000, 12'd1000, 12'd3000, 16'd200);
		send_sample(12'd0);
		send_sample(12'd999);
		send_sample(12'd3001);
		send_sample(12'hFFF);
		send_sample(12'd2000);
	endtask

	task automatic test_empty_span();
		drain_results();
		write_setting(16'd1234, 16'd60000, 12'd2000, 12'd2000, 16'd1000);
		send_sample(12'd2000);
		send_sample(12'hFFF);
		// Reversed span
		drain_results();
		write_setting(16'd777, 16'd9999, 12'd3000, 12'd10, 16'd1000);
		send_sample(12'd5);
	endtask

	task automatic test_threshold_and_sum();
		drain_results();
		// Nothing qualifies: the mean is held
		write_setting(16'h0000, 16'hFFFF, 12'd0, 12'd4095, 16'hFFFF);
		send_sample(12'hFFF);
		// Several full-scale entries push the sum past 16 bits
		drain_results();
		write_register(cpa_pkg::REG_VALID_THRESHOLD, 16'hFFFE);
		send_sample(12'hFFF);
		send_sample(12'hFFF);
		send_sample(12'hFFF);
	endtask

	task automatic test_ignored_registers();
		drain_results();
		for (int i = int'(cpa_pkg::REG_VALID_THRESHOLD) + 1; i < (1 << CFG_IDX_W); i++)
			write_register(CFG_IDX_W'(i), (i[0]) ? 16'hFFFF : 16'($urandom));
		send_sample(12'd100);
		send_sample(12'hC00);
	endtask

	// Pick a register setting, extremes included
	task automatic pick_random_setting();
		logic [PRESS_W-1:0]  p_low;
		logic [PRESS_W-1:0]  p_high;
		logic [SAMPLE_W-1:0] a_low;
		logic [SAMPLE_W-1:0] a_high;
		logic [SAMPLE_W-1:0] swap;
		logic [PRESS_W-1:0]  thr;
		p_low = 16'($urandom);
		p_high = 16'($urandom);
		a_low = 12'($urandom);
		a_high = 12'($urandom);
		if (a_low > a_high) begin
			swap = a_low;
			a_low = a_high;
			a_high = swap;
		end
		case ($urandom_range(0, 5))
			0: begin
				p_low = '0;
				p_high = '1;
				a_low = '0;
				a_high = '1;
			end
			1: begin
				p_low = '1;
				p_high = '0;
			end
			2: begin
				if (a_low == '1)
					a_low = a_low - 1'b1;
				a_high = a_low + 1'b1;
			end
			3: a_high = 12'($urandom_range(0, a_low));
			default: ;
		endcase
		case ($urandom_range(0, 3))
			0: thr = '0;
			1: thr = '1;
			2: thr = 16'($urandom);
			default: thr = (p_low < p_high) ? 16'($urandom_range(p_low, p_high))
				: 16'($urandom_range(p_high, p_low));
		endcase
		write_setting(p_low, p_high, a_low, a_high, thr);
		if ($urandom_range(0, 3) == 0)
			write_register(CFG_IDX_W'($urandom_range(int'(cpa_pkg::REG_VALID_THRESHOLD) + 1,
				(1 << CFG_IDX_W) - 1)), 16'($urandom));
	endtask

	// Mostly inside the span, some anywhere, some at the edges
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return SAMPLE_W'($urandom_range(cfg_adc_low, cfg_adc_high));
		if (pick < 85)
			return SAMPLE_W'($urandom);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return cfg_adc_low;
			3: return cfg_adc_high;
			4: return cfg_adc_low - 1'b1;
			default: return cfg_adc_high + 1'b1;
		endcase
	endfunction

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			for (int set = 0; set < SETS_PER_PHASE; set++) begin
				drain_results();
				pick_random_setting();
				for (int n = 0; n < SAMPLES_PER_SET; n++) begin
					send_sample(pick_sample());
					if ($urandom_range(0, 99) == 0)
						drain_results();
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.adc_sample = '0;
		result_ch.ready = 1'b0;
		// Reset values of the predictor
		cfg_pressure_low = 16'd0;
		cfg_pressure_high = 16'd1;
		cfg_adc_low = 12'd0;
		cfg_adc_high = 12'd4095;
		cfg_threshold = 16'd0;
		foreach (pressure_ring[i])
			pressure_ring[i] = '0;
		ring_slot = 0;
		held_mean = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_scaling();
		test_empty_span();
		test_threshold_and_sum();
		test_ignored_registers();
		test_random_traffic();

		// Let the last results arrive, then watch for strays
		drain_results();
		repeat (100) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 0, pending_results.size());
		if (mismatch_count == 0)
			$display("current_loop_pressure_averager: match");
		else
			$display("current_loop_pressure_averager: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/cpa_pkg.sv
rtl/core/cpa_if.sv
rtl/core/cpa_div.sv
rtl/core/cpa_ring.sv
rtl/core/current_loop_pressure_averager.sv
sim/tb_current_loop_pressure_averager.sv
